@@ design/bitmap_font_text_blitter_macros.svh @@
// Assertion macros shared by the blitter RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef BITMAP_FONT_TEXT_BLITTER_MACROS_SVH
`define BITMAP_FONT_TEXT_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define BFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define BFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BFB_ASSERT(lbl, prop, msg)
`define BFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/bfb_pkg.sv @@
// Package of the bitmap font text blitter: sizes, codes and payload types.
// Depends on nothing; imported by bfb_if, bfb_frame, bfb_cfg and the top level.
package bfb_pkg;

  localparam int unsigned CODE_ENTRIES = 128;
  localparam int unsigned GLYPH_BYTES  = 1024;
  localparam int unsigned FB_COLUMNS   = 32;
  localparam int unsigned FONT_COUNT   = 2;

  localparam int unsigned CODE_AW      = $clog2(CODE_ENTRIES);
  localparam int unsigned GLYPH_AW     = $clog2(GLYPH_BYTES);
  localparam int unsigned FB_AW        = $clog2(FB_COLUMNS);
  localparam int unsigned FONT_AW      = $clog2(FONT_COUNT);

  localparam int unsigned CODE_MEM_DEPTH  = FONT_COUNT << CODE_AW;
  localparam int unsigned CODE_MEM_AW     = FONT_AW + CODE_AW;
  localparam int unsigned GLYPH_MEM_DEPTH = FONT_COUNT << GLYPH_AW;
  localparam int unsigned GLYPH_MEM_AW    = FONT_AW + GLYPH_AW;

  localparam int unsigned CODE_W       = 18;
  localparam logic [7:0]  END_CODE     = 8'hFF;
  localparam logic [3:0]  MAX_GLYPH_DIM = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD_CODE  = 2'd0,
    OP_LOAD_GLYPH = 2'd1,
    OP_RENDER     = 2'd2,
    OP_READ_COL   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_FONT0_WIDTH  = 2'd0,
    CFG_FONT0_HEIGHT = 2'd1,
    CFG_FONT1_WIDTH  = 2'd2,
    CFG_FONT1_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    opcode_e     opcode;
    logic        font_select;
    logic [6:0]  entry_index;
    logic [7:0]  char_code;
    logic [9:0]  glyph_offset;
    logic [7:0]  glyph_byte;
    logic        start_of_text;
    logic [4:0]  start_column;
    logic [5:0]  column_budget;
    logic [2:0]  row_offset;
    logic        invert;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  column_data;
    logic [3:0]  glyph_columns;
    logic        found;
    logic [7:0]  total_columns;
    logic [5:0]  budget_left;
    logic        text_done;
  } out_item_t;

  // Glyph geometry of the selected font, already clamped to 0..8.
  typedef struct packed {
    logic [3:0]  width;
    logic [3:0]  height;
  } geom_t;

endpackage

@@ design/bfb_if.sv @@
// Valid/ready stream interfaces for the blitter input and result channels.
// Depends on bfb_pkg for the payload types.
interface bfb_in_if import bfb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfb_out_if import bfb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bfb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bfb_ram #(
  parameter  int unsigned DEPTH = 256,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bfb_frame.sv @@
// Framebuffer column store: a RAM plus one valid bit per column.
// Depends on bfb_pkg and bfb_ram; unwritten columns read as zero.
module bfb_frame import bfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [FB_AW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [FB_AW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [FB_COLUMNS-1:0] valid_q;
  logic                  rvalid_q;
  logic [7:0]            ram_rdata;

  bfb_ram #(
    .DEPTH (FB_COLUMNS),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Mark a column as holding real data once it is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (re_i) begin
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : 8'h00;

endmodule

@@ design/bfb_cfg.sv @@
// Font geometry registers and the clamp to at most eight columns and rows.
// Depends on bfb_pkg.
module bfb_cfg import bfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  cfg_idx_e   idx_i,
  input  logic [3:0] wdata_i,
  input  logic       font_i,
  output geom_t      geom_o
);

  logic [3:0] f0_width_q, f0_height_q, f1_width_q, f1_height_q;
  logic [3:0] width_raw, height_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_width_q  <= 4'd6;
      f0_height_q <= 4'd8;
      f1_width_q  <= 4'd4;
      f1_height_q <= 4'd5;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_FONT0_WIDTH:  f0_width_q  <= wdata_i;
        CFG_FONT0_HEIGHT: f0_height_q <= wdata_i;
        CFG_FONT1_WIDTH:  f1_width_q  <= wdata_i;
        CFG_FONT1_HEIGHT: f1_height_q <= wdata_i;
        default: ;
      endcase
    end
  end

  assign width_raw  = font_i ? f1_width_q  : f0_width_q;
  assign height_raw = font_i ? f1_height_q : f0_height_q;

  assign geom_o.width  = (width_raw  > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : width_raw;
  assign geom_o.height = (height_raw > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : height_raw;

endmodule

@@ design/bitmap_font_text_blitter.sv @@
// Bitmap font text blitter. One transaction in gives exactly one transaction out.
// Loads (code entry, glyph byte) write their RAM in DECODE and then finish; a column
// read goes through DECODE and READ_WAIT. A render walks the code table slots (one
// per clock through the code table read port, at most CODE_ENTRIES), then stamps the
// glyph columns (one per clock through the glyph and framebuffer ports) and drains
// the write stage; the code table walk dominates.
// The next transaction is taken once the previous result sits in the output
// register, even if the sink has not taken it yet. Fonts live in two RAMs (code
// table, glyph store) that read as undefined until loaded; the framebuffer RAM
// carries per-column valid bits so it reads as zero after reset with no clearing pass.
// Depends on bfb_pkg, bfb_if, bfb_ram, bfb_frame, bfb_cfg and the macros header.
`include "bitmap_font_text_blitter_macros.svh"

module bitmap_font_text_blitter import bfb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  bfb_in_if.sink         in_i,
  bfb_out_if.source      out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [3:0]     cfg_wdata_i
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECODE    = 7'b0000010,
    S_READ_WAIT = 7'b0000100,
    S_SEARCH    = 7'b0001000,
    S_STAMP     = 7'b0010000,
    S_SPACE     = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Item and text cursor state.
  in_item_t           item_q, item_d;
  logic [6:0]         cursor_q, cursor_d;
  logic [5:0]         budget_q, budget_d;
  logic [7:0]         total_q, total_d;

  // Per-item working registers.
  logic [7:0]         coldata_q, coldata_d;
  logic [3:0]         drawn_q, drawn_d;
  logic               hit_q, hit_d;
  logic [CODE_AW-1:0] slot_q, slot_d;
  logic [9:0]         base_q, base_d;
  logic [3:0]         rd_i_q, rd_i_d;

  // Stamp write stage: column whose glyph and frame bytes arrive this cycle.
  logic               wr_valid_q, wr_valid_d;
  logic               wr_col_ok_q, wr_col_ok_d;
  logic               wr_g_ok_q, wr_g_ok_d;
  logic [FB_AW-1:0]   wr_col_q, wr_col_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  // Memory ports.
  logic                     code_we, code_re;
  logic [CODE_MEM_AW-1:0]   code_waddr, code_raddr;
  logic [CODE_W-1:0]        code_rdata;
  logic [CODE_AW-1:0]       code_rslot;
  logic                     glyph_we, glyph_re;
  logic [GLYPH_MEM_AW-1:0]  glyph_waddr, glyph_raddr;
  logic [7:0]               glyph_rdata;
  logic                     frame_we, frame_re;
  logic [FB_AW-1:0]         frame_raddr;
  logic [7:0]               frame_rdata, frame_wdata;

  geom_t              geom;

  // Combinational helpers.
  logic               font_ok, code_ok, glyph_ok, rcol_ok, out_free;
  logic [6:0]         cur_e;
  logic [5:0]         bud_e;
  logic [7:0]         tot_e;
  logic [7:0]         hit_chr;
  logic [9:0]         hit_off;
  logic [3:0]         n_draw;
  logic [10:0]        g_addr;
  logic [7:0]         s_col;
  logic               s_issue, s_col_ok, s_g_ok;
  logic [7:0]         h_ones, mask, g_bits, g_shift, g_stamp;
  logic [6:0]         sp_cur;
  logic [5:0]         sp_bud;
  logic [7:0]         sp_tot;

  bfb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_e'(cfg_idx_i)),
    .wdata_i (cfg_wdata_i),
    .font_i  (item_q.font_select),
    .geom_o  (geom)
  );

  bfb_ram #(
    .DEPTH (CODE_MEM_DEPTH),
    .WIDTH (CODE_W)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (code_waddr),
    .wdata_i ({item_q.char_code, item_q.glyph_offset}),
    .re_i    (code_re),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  bfb_ram #(
    .DEPTH (GLYPH_MEM_DEPTH),
    .WIDTH (8)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (glyph_waddr),
    .wdata_i (item_q.glyph_byte),
    .re_i    (glyph_re),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rdata)
  );

  bfb_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (frame_we),
    .waddr_i (wr_col_q),
    .wdata_i (frame_wdata),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  // Range checks; out-of-range loads are dropped, absent fonts never match.
  assign font_ok  = item_q.font_select < FONT_COUNT;
  assign code_ok  = font_ok && (item_q.entry_index < CODE_ENTRIES);
  assign glyph_ok = font_ok && (item_q.glyph_offset < GLYPH_BYTES);
  assign rcol_ok  = item_q.start_column < FB_COLUMNS;

  // Start of text reloads cursor, budget and total before the character is drawn.
  assign cur_e = item_q.start_of_text ? 7'(item_q.start_column) : cursor_q;
  assign bud_e = item_q.start_of_text ? item_q.column_budget : budget_q;
  assign tot_e = item_q.start_of_text ? 8'h00 : total_q;

  // Code table walk: slot 0 is read in DECODE, then one slot ahead each cycle.
  assign code_rslot = (state_q == S_SEARCH) ? CODE_AW'(slot_q + 1'b1) : '0;
  assign code_raddr = CODE_MEM_AW'({item_q.font_select, code_rslot});
  assign code_re    = (state_q == S_DECODE) || (state_q == S_SEARCH);
  assign code_waddr = CODE_MEM_AW'({item_q.font_select, CODE_AW'(item_q.entry_index)});
  assign code_we    = (state_q == S_DECODE) && (item_q.opcode == OP_LOAD_CODE) && code_ok;
  assign hit_chr    = code_rdata[CODE_W-1 -: 8];
  assign hit_off    = code_rdata[9:0];
  assign n_draw     = (6'(geom.width) < budget_q) ? geom.width : 4'(budget_q);

  // Stamp issue side: glyph byte and old frame byte for column rd_i_q.
  assign s_issue     = (state_q == S_STAMP) && (rd_i_q < drawn_q);
  assign g_addr      = 11'(base_q) + 11'(rd_i_q);
  assign s_g_ok      = g_addr < GLYPH_BYTES;
  assign s_col       = 8'(cursor_q) + 8'(rd_i_q);
  assign s_col_ok    = s_col < FB_COLUMNS;
  assign glyph_raddr = GLYPH_MEM_AW'({item_q.font_select, GLYPH_AW'(g_addr)});
  assign glyph_re    = s_issue;
  assign glyph_waddr = GLYPH_MEM_AW'({item_q.font_select, GLYPH_AW'(item_q.glyph_offset)});
  assign glyph_we    = (state_q == S_DECODE) && (item_q.opcode == OP_LOAD_GLYPH) && glyph_ok;

  // Frame port serves column reads in DECODE and stamp reads in STAMP.
  assign frame_raddr = (state_q == S_STAMP) ? FB_AW'(s_col) : FB_AW'(item_q.start_column);
  assign frame_re    = (s_issue && s_col_ok) ||
                       ((state_q == S_DECODE) && (item_q.opcode == OP_READ_COL) && rcol_ok);

  // Stamp write side: shift, optionally invert, and merge under the height mask.
  assign h_ones      = 8'((9'd1 << geom.height) - 9'd1);
  assign mask        = h_ones << item_q.row_offset;
  assign g_bits      = wr_g_ok_q ? glyph_rdata : 8'h00;
  assign g_shift     = g_bits << item_q.row_offset;
  assign g_stamp     = item_q.invert ? ~g_shift : g_shift;
  assign frame_wdata = (frame_rdata & ~mask) | (g_stamp & mask);
  assign frame_we    = wr_valid_q && wr_col_ok_q;

  // Advance past the drawn columns, then take one spacing column if budget remains.
  assign sp_cur = cursor_q + 7'(drawn_q);
  assign sp_bud = budget_q - 6'(drawn_q);
  assign sp_tot = total_q + 8'(drawn_q);

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cursor_d    = cursor_q;
    budget_d    = budget_q;
    total_d     = total_q;
    coldata_d   = coldata_q;
    drawn_d     = drawn_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    base_d      = base_q;
    rd_i_d      = rd_i_q;
    wr_valid_d  = 1'b0;
    wr_col_ok_d = wr_col_ok_q;
    wr_g_ok_d   = wr_g_ok_q;
    wr_col_d    = wr_col_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d  = in_i.data;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        coldata_d = 8'h00;
        drawn_d   = 4'd0;
        hit_d     = 1'b0;
        slot_d    = '0;
        case (item_q.opcode)
          OP_READ_COL: state_d = S_READ_WAIT;
          OP_RENDER: begin
            cursor_d = cur_e;
            budget_d = bud_e;
            total_d  = tot_e;
            if (bud_e == 6'd0) begin
              state_d = S_FINISH;
            end else if (item_q.char_code == 8'h00) begin
              // Null character ends the text: drop the rest of the budget.
              budget_d = 6'd0;
              state_d  = S_FINISH;
            end else if (font_ok) begin
              state_d = S_SEARCH;
            end else begin
              state_d = S_SPACE;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end

      S_READ_WAIT: begin
        if (rcol_ok) begin
          coldata_d = frame_rdata;
        end
        state_d = S_FINISH;
      end

      S_SEARCH: begin
        if (hit_chr == END_CODE) begin
          state_d = S_SPACE;
        end else if (hit_chr == item_q.char_code) begin
          hit_d   = 1'b1;
          base_d  = hit_off;
          drawn_d = n_draw;
          rd_i_d  = 4'd0;
          state_d = (n_draw == 4'd0) ? S_SPACE : S_STAMP;
        end else if (slot_q == CODE_AW'(CODE_ENTRIES - 1)) begin
          state_d = S_SPACE;
        end else begin
          slot_d = CODE_AW'(slot_q + 1'b1);
        end
      end

      S_STAMP: begin
        if (s_issue) begin
          rd_i_d      = rd_i_q + 4'd1;
          wr_valid_d  = 1'b1;
          wr_col_ok_d = s_col_ok;
          wr_g_ok_d   = s_g_ok;
          wr_col_d    = FB_AW'(s_col);
        end else if (!wr_valid_q) begin
          state_d = S_SPACE;
        end
      end

      S_SPACE: begin
        if (sp_bud != 6'd0) begin
          cursor_d = sp_cur + 7'd1;
          budget_d = sp_bud - 6'd1;
          total_d  = sp_tot + 8'd1;
        end else begin
          cursor_d = sp_cur;
          budget_d = sp_bud;
          total_d  = sp_tot;
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // Hold the result here until the output register frees up.
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.column_data   = coldata_q;
          out_data_d.glyph_columns = drawn_q;
          out_data_d.found         = hit_q;
          out_data_d.total_columns = total_q;
          out_data_d.budget_left   = budget_q;
          out_data_d.text_done     = (budget_q == 6'd0);
          state_d                  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= 7'd0;
      budget_q    <= 6'd0;
      total_q     <= 8'd0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      budget_q    <= budget_d;
      total_q     <= total_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    coldata_q   <= coldata_d;
    drawn_q     <= drawn_d;
    hit_q       <= hit_d;
    slot_q      <= slot_d;
    base_q      <= base_d;
    rd_i_q      <= rd_i_d;
    wr_col_ok_q <= wr_col_ok_d;
    wr_g_ok_q   <= wr_g_ok_d;
    wr_col_q    <= wr_col_d;
    out_data_q  <= out_data_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The budget only grows when a new text starts.
  `BFB_ASSERT(a_budget_no_grow, (state_q != S_DECODE) |=> (budget_q <= $past(budget_q)),
    "budget grew outside start of text")
  // A result never reports drawn columns without a hit, nor more than eight.
  `BFB_ASSERT(a_drawn_sane, (state_q == S_FINISH) |->
    ((drawn_q <= MAX_GLYPH_DIM) && (hit_q || (drawn_q == 4'd0))),
    "drawn column count inconsistent with hit")
  // The stamp walk never issues past the drawn column count.
  `BFB_ASSERT(a_stamp_bound, (state_q == S_STAMP) |-> (rd_i_q <= drawn_q),
    "stamp index ran past column count")

endmodule
